/* src/perspective_point_transform_macros.svh */
// ---------------------------------------------------------------------------
// perspective point transform assertion macros
// shared property forms for the point transform checks
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_TRANSFORM_MACROS_SVH
`define PERSPECTIVE_POINT_TRANSFORM_MACROS_SVH

// same-cycle implication, disabled in reset
`define PPT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt check failed");

// next-cycle implication, disabled in reset
`define PPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt check failed");

`endif

/* src/ppt_pkg.sv */
// ---------------------------------------------------------------------------
// ppt_pkg
// widths, register indexes and stage numbers of the point transform
// ---------------------------------------------------------------------------
package ppt_pkg;

    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 16;
    localparam int COORD_W    = 16;
    localparam int OUT_W      = 32;
    localparam int OUT_FRAC   = 16;

    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = SUM_W;
    // quotient carries one extra bit for rounding
    localparam int QF_BITS    = OUT_FRAC + 1;
    localparam int Q_W        = OUT_FRAC + QF_BITS;
    localparam int REM_W      = MAG_W + QF_BITS;

    localparam int RSH        = (COEF_FRAC > OUT_FRAC) ? COEF_FRAC - OUT_FRAC : 0;
    localparam int RSH_M1     = (RSH > 0) ? RSH - 1 : 0;
    localparam int LSH        = (COEF_FRAC < OUT_FRAC) ? OUT_FRAC - COEF_FRAC : 0;
    localparam int AFF_W      = MAG_W + LSH;
    localparam int FIN_W      = (AFF_W > Q_W + 1) ? AFF_W : Q_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2 * COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C01   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C23   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C45   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C67   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C8    = 3'd5;

    localparam logic MODE_AFFINE      = 1'b0;
    localparam logic MODE_PERSPECTIVE = 1'b1;

    localparam int S_MUL = 0;
    localparam int S_SUM = 1;
    localparam int S_MAG = 2;
    localparam int S_CHK = 3;
    localparam int S_RND = S_CHK + Q_W + 1;
    localparam int S_OUT = S_RND + 1;
    localparam int N_ST  = S_OUT + 1;

endpackage

/* src/perspective_point_transform.sv */
// ---------------------------------------------------------------------------
// perspective_point_transform
// pipelined 3x3 homography point mapper, signed q16.16 results
// ---------------------------------------------------------------------------
//  channel   signals                                 direction
//  input     i_valid, o_stall, i_x, i_y              word in
//  output    o_valid, i_stall, o_out_x, o_out_y,     word out
//            o_zero_denominator, o_overflow
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata        write only
//
//  one word per clock unless i_stall holds a full pipe; the restoring divider
//  resolves one quotient bit per stage
//  reset (synchronous, active low) empties the pipe and loads identity coefs
//  each stage moves when it is empty or the stage after it moves, so bubbles
//  close up and input is taken while the output register is held
// ---------------------------------------------------------------------------
`include "perspective_point_transform_macros.svh"

module perspective_point_transform (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [ppt_pkg::COORD_W-1:0]     i_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]     i_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [ppt_pkg::OUT_W-1:0]       o_out_x,
    output logic signed [ppt_pkg::OUT_W-1:0]       o_out_y,
    output logic                                   o_zero_denominator,
    output logic                                   o_overflow
);

    localparam int COEF_W = ppt_pkg::COEF_W;
    localparam int PROD_W = ppt_pkg::PROD_W;
    localparam int SUM_W  = ppt_pkg::SUM_W;
    localparam int MAG_W  = ppt_pkg::MAG_W;
    localparam int REM_W  = ppt_pkg::REM_W;
    localparam int Q_W    = ppt_pkg::Q_W;
    localparam int AFF_W  = ppt_pkg::AFF_W;
    localparam int FIN_W  = ppt_pkg::FIN_W;
    localparam int OUT_W  = ppt_pkg::OUT_W;
    localparam int N_ST   = ppt_pkg::N_ST;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    // configuration
    logic                     r_mode;
    logic signed [COEF_W-1:0] r_coef [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ppt_pkg::MODE_AFFINE;
            // identity: diagonal coefficients are one
            for (int k = 0; k < 9; k++) begin
                r_coef[k] <= (k == 0 || k == 4 || k == 8) ?
                             (COEF_W'(1) << ppt_pkg::COEF_FRAC) : '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppt_pkg::CFG_MODE: r_mode <= i_cfg_wdata[0];
                ppt_pkg::CFG_C01: begin
                    r_coef[0] <= i_cfg_wdata[2*COEF_W-1:COEF_W];
                    r_coef[1] <= i_cfg_wdata[COEF_W-1:0];
                end
                ppt_pkg::CFG_C23: begin
                    r_coef[2] <= i_cfg_wdata[2*COEF_W-1:COEF_W];
                    r_coef[3] <= i_cfg_wdata[COEF_W-1:0];
                end
                ppt_pkg::CFG_C45: begin
                    r_coef[4] <= i_cfg_wdata[2*COEF_W-1:COEF_W];
                    r_coef[5] <= i_cfg_wdata[COEF_W-1:0];
                end
                ppt_pkg::CFG_C67: begin
                    r_coef[6] <= i_cfg_wdata[2*COEF_W-1:COEF_W];
                    r_coef[7] <= i_cfg_wdata[COEF_W-1:0];
                end
                ppt_pkg::CFG_C8: r_coef[8] <= i_cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic [N_ST-1:0] r_v;
    logic [N_ST-1:0] w_en;

    for (genvar i = 0; i < N_ST; i++) begin : g_en
        // a stage moves unless it and every stage after it are full and stalled
        assign w_en[i] = !i_stall || !(&r_v[N_ST-1:i]);
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[N_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < N_ST; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    // multiply stage
    logic signed [PROD_W-1:0] r0_p [0:5];

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_MUL]) begin
            r0_p[0] <= r_coef[0] * i_x;
            r0_p[1] <= r_coef[1] * i_y;
            r0_p[2] <= r_coef[3] * i_x;
            r0_p[3] <= r_coef[4] * i_y;
            r0_p[4] <= r_coef[6] * i_x;
            r0_p[5] <= r_coef[7] * i_y;
        end
    end

    // row sums
    logic signed [SUM_W-1:0] r1_nx, r1_ny, r1_den;

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_SUM]) begin
            r1_nx  <= SUM_W'(r0_p[0]) + SUM_W'(r0_p[1]) + SUM_W'(r_coef[2]);
            r1_ny  <= SUM_W'(r0_p[2]) + SUM_W'(r0_p[3]) + SUM_W'(r_coef[5]);
            r1_den <= SUM_W'(r0_p[4]) + SUM_W'(r0_p[5]) + SUM_W'(r_coef[8]);
        end
    end

    // magnitudes and signs
    logic [MAG_W-1:0] r2_mag_x, r2_mag_y, r2_mag_d;
    logic             r2_neg_x, r2_neg_y, r2_zden;
    logic             n_neg_x, n_neg_y, n_dzero;

    always_comb begin
        n_dzero = (r1_den == '0);
        if (r_mode == ppt_pkg::MODE_AFFINE || n_dzero) begin
            n_neg_x = r1_nx[SUM_W-1];
            n_neg_y = r1_ny[SUM_W-1];
        end else begin
            n_neg_x = (r1_nx[SUM_W-1] ^ r1_den[SUM_W-1]) && (r1_nx != '0);
            n_neg_y = (r1_ny[SUM_W-1] ^ r1_den[SUM_W-1]) && (r1_ny != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_MAG]) begin
            r2_mag_x <= r1_nx[SUM_W-1]  ? MAG_W'(-r1_nx)  : MAG_W'(r1_nx);
            r2_mag_y <= r1_ny[SUM_W-1]  ? MAG_W'(-r1_ny)  : MAG_W'(r1_ny);
            r2_mag_d <= r1_den[SUM_W-1] ? MAG_W'(-r1_den) : MAG_W'(r1_den);
            r2_neg_x <= n_neg_x;
            r2_neg_y <= n_neg_y;
            r2_zden  <= (r_mode == ppt_pkg::MODE_PERSPECTIVE) && n_dzero;
        end
    end

    // divider lanes; index 0 is the range check stage
    logic [REM_W-1:0] r_rem_x [0:Q_W];
    logic [REM_W-1:0] r_rem_y [0:Q_W];
    logic [Q_W-1:0]   r_q_x   [0:Q_W];
    logic [Q_W-1:0]   r_q_y   [0:Q_W];
    logic [MAG_W-1:0] r_dv_d  [0:Q_W];
    logic [AFF_W-1:0] r_aff_x [0:Q_W];
    logic [AFF_W-1:0] r_aff_y [0:Q_W];
    logic             r_big_x [0:Q_W];
    logic             r_big_y [0:Q_W];
    logic             r_neg_x [0:Q_W];
    logic             r_neg_y [0:Q_W];
    logic             r_zden  [0:Q_W];

    function automatic logic [AFF_W-1:0] rescale(input logic [MAG_W-1:0] mag);
        logic [AFF_W-1:0] v;
        v = AFF_W'(mag);
        if (ppt_pkg::RSH > 0) begin
            rescale = (v >> ppt_pkg::RSH) + AFF_W'((v >> ppt_pkg::RSH_M1) & AFF_W'(1));
        end else begin
            rescale = v << ppt_pkg::LSH;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_CHK]) begin
            r_rem_x[0] <= REM_W'(r2_mag_x) << ppt_pkg::QF_BITS;
            r_rem_y[0] <= REM_W'(r2_mag_y) << ppt_pkg::QF_BITS;
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_dv_d[0]  <= r2_mag_d;
            r_aff_x[0] <= rescale(r2_mag_x);
            r_aff_y[0] <= rescale(r2_mag_y);
            // integer part would not fit the quotient
            r_big_x[0] <= (MAG_W+16)'(r2_mag_x) >= ((MAG_W+16)'(r2_mag_d) << 16);
            r_big_y[0] <= (MAG_W+16)'(r2_mag_y) >= ((MAG_W+16)'(r2_mag_d) << 16);
            r_neg_x[0] <= r2_neg_x;
            r_neg_y[0] <= r2_neg_y;
            r_zden[0]  <= r2_zden;
        end
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_div
        localparam int K = Q_W - j;
        logic [REM_W-1:0] w_dext;
        logic             w_tx, w_ty;

        assign w_dext = REM_W'(r_dv_d[j-1]);
        assign w_tx   = (r_rem_x[j-1] >> K) >= w_dext;
        assign w_ty   = (r_rem_y[j-1] >> K) >= w_dext;

        always_ff @(posedge i_clk) begin
            if (w_en[ppt_pkg::S_CHK + j]) begin
                r_rem_x[j] <= w_tx ? r_rem_x[j-1] - (w_dext << K) : r_rem_x[j-1];
                r_rem_y[j] <= w_ty ? r_rem_y[j-1] - (w_dext << K) : r_rem_y[j-1];
                r_q_x[j]   <= r_q_x[j-1] | (Q_W'(w_tx) << K);
                r_q_y[j]   <= r_q_y[j-1] | (Q_W'(w_ty) << K);
                r_dv_d[j]  <= r_dv_d[j-1];
                r_aff_x[j] <= r_aff_x[j-1];
                r_aff_y[j] <= r_aff_y[j-1];
                r_big_x[j] <= r_big_x[j-1];
                r_big_y[j] <= r_big_y[j-1];
                r_neg_x[j] <= r_neg_x[j-1];
                r_neg_y[j] <= r_neg_y[j-1];
                r_zden[j]  <= r_zden[j-1];
            end
        end
    end

    // rounding and path select
    logic [FIN_W-1:0] r4_mag_x, r4_mag_y;
    logic             r4_force_x, r4_force_y, r4_neg_x, r4_neg_y, r4_zden;

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_RND]) begin
            if (r_mode == ppt_pkg::MODE_AFFINE) begin
                r4_mag_x   <= FIN_W'(r_aff_x[Q_W]);
                r4_mag_y   <= FIN_W'(r_aff_y[Q_W]);
                r4_force_x <= 1'b0;
                r4_force_y <= 1'b0;
            end else begin
                r4_mag_x   <= FIN_W'(r_q_x[Q_W] >> 1) + FIN_W'(r_q_x[Q_W][0]);
                r4_mag_y   <= FIN_W'(r_q_y[Q_W] >> 1) + FIN_W'(r_q_y[Q_W][0]);
                r4_force_x <= r_zden[Q_W] || r_big_x[Q_W];
                r4_force_y <= r_zden[Q_W] || r_big_y[Q_W];
            end
            r4_neg_x <= r_neg_x[Q_W];
            r4_neg_y <= r_neg_y[Q_W];
            r4_zden  <= r_zden[Q_W];
        end
    end

    // saturation into the output register
    logic [OUT_W-1:0] n_ox, n_oy;
    logic             n_ovf_x, n_ovf_y;

    always_comb begin
        n_ovf_x = r4_force_x || (r4_neg_x ? r4_mag_x > FIN_W'(SAT_NEG)
                                          : r4_mag_x > FIN_W'(SAT_POS));
        n_ovf_y = r4_force_y || (r4_neg_y ? r4_mag_y > FIN_W'(SAT_NEG)
                                          : r4_mag_y > FIN_W'(SAT_POS));
        if (n_ovf_x) begin
            n_ox = r4_neg_x ? SAT_NEG : SAT_POS;
        end else begin
            n_ox = r4_neg_x ? OUT_W'(-r4_mag_x) : OUT_W'(r4_mag_x);
        end
        if (n_ovf_y) begin
            n_oy = r4_neg_y ? SAT_NEG : SAT_POS;
        end else begin
            n_oy = r4_neg_y ? OUT_W'(-r4_mag_y) : OUT_W'(r4_mag_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ppt_pkg::S_OUT]) begin
            o_out_x            <= n_ox;
            o_out_y            <= n_oy;
            o_overflow         <= n_ovf_x || n_ovf_y;
            o_zero_denominator <= r4_zden;
        end
    end

    // checks
    logic w_out_sat, w_persp;

    assign w_out_sat = (o_out_x == SAT_POS || o_out_x == SAT_NEG) &&
                       (o_out_y == SAT_POS || o_out_y == SAT_NEG);
    assign w_persp   = (r_mode == ppt_pkg::MODE_PERSPECTIVE);

    `PPT_ASSERT_NOW(a_zden_ovf, i_clk, i_rst_n, o_valid && o_zero_denominator, o_overflow)
    `PPT_ASSERT_NOW(a_zden_mode, i_clk, i_rst_n, o_valid && o_zero_denominator, w_persp)
    `PPT_ASSERT_NOW(a_zden_sat, i_clk, i_rst_n, o_valid && o_zero_denominator, w_out_sat)
    `PPT_ASSERT_NEXT(a_take, i_clk, i_rst_n, i_valid && !o_stall, r_v[ppt_pkg::S_MUL])

endmodule

/* verif/perspective_point_transform_checker.sv */
// ---------------------------------------------------------------------------
// perspective_point_transform_checker
// watches the point and result channels, predicts each result from the
// coefficients written so far and compares field by field
// ---------------------------------------------------------------------------
module perspective_point_transform_checker
    import ppt_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                          i_valid,
    input  logic                          i_in_stall,
    input  logic signed [COORD_W-1:0]     i_x,
    input  logic signed [COORD_W-1:0]     i_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [OUT_W-1:0]       i_out_x,
    input  logic signed [OUT_W-1:0]       i_out_y,
    input  logic                          i_zero_denominator,
    input  logic                          i_overflow,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results_seen,
    output int                            o_zden_seen,
    output int                            o_ovf_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic        zden;
        logic        ovf;
    } point_result_t;

    logic               persp_mode;
    logic signed [31:0] coef [9];
    point_result_t      expected_points [$];

    function automatic logic [63:0] mag64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] clamp_q16(input logic neg, input logic [63:0] m,
                                              inout logic ovf);
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) begin
                ovf = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return m[31:0];
        end
        if (m > 64'h8000_0000) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return 32'h0 - m[31:0];
    endfunction

    // rounded n/d with 16 fraction bits, ties away from zero
    function automatic logic [63:0] q16_quotient(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q0, r, f;
        q0 = n / d;
        r  = n % d;
        f  = 0;
        if (q0 >= 64'h1_0000) return 64'h1 << 40;
        for (int i = 0; i < 17; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= d) begin
                r = r - d;
                f[0] = 1'b1;
            end
        end
        return (q0 << 16) + (f >> 1) + f[0];
    endfunction

    function automatic point_result_t map_point(input logic signed [15:0] x,
                                                input logic signed [15:0] y);
        point_result_t res;
        longint nx, ny, den;
        logic ovf;
        logic [63:0] dm;
        nx  = longint'(coef[0]) * x + longint'(coef[1]) * y + longint'(coef[2]);
        ny  = longint'(coef[3]) * x + longint'(coef[4]) * y + longint'(coef[5]);
        den = longint'(coef[6]) * x + longint'(coef[7]) * y + longint'(coef[8]);
        ovf = 1'b0;
        res.zden = 1'b0;
        if (persp_mode == MODE_AFFINE) begin
            res.px = clamp_q16(nx < 0, mag64(nx), ovf);
            res.py = clamp_q16(ny < 0, mag64(ny), ovf);
        end else if (den == 0) begin
            res.zden = 1'b1;
            ovf = 1'b1;
            res.px = (nx < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res.py = (ny < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            dm = mag64(den);
            res.px = clamp_q16(((nx < 0) != (den < 0)) && nx != 0,
                               q16_quotient(mag64(nx), dm), ovf);
            res.py = clamp_q16(((ny < 0) != (den < 0)) && ny != 0,
                               q16_quotient(mag64(ny), dm), ovf);
        end
        res.ovf = ovf;
        return res;
    endfunction

    assign o_pending = expected_points.size();

    always @(posedge i_clk) begin
        point_result_t want;
        logic          mismatch;
        mismatch = 1'b0;
        if (!i_rst_n) begin
            persp_mode <= MODE_AFFINE;
            // identity: diagonal coefficients are one
            for (int k = 0; k < 9; k++)
                coef[k] <= (k == 0 || k == 4 || k == 8) ? 32'h1_0000 : 32'h0;
            expected_points.delete();
            o_fail_count   <= 0;
            o_results_seen <= 0;
            o_zden_seen    <= 0;
            o_ovf_seen     <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: persp_mode <= i_cfg_wdata[0];
                    CFG_C01: begin
                        coef[0] <= i_cfg_wdata[63:32];
                        coef[1] <= i_cfg_wdata[31:0];
                    end
                    CFG_C23: begin
                        coef[2] <= i_cfg_wdata[63:32];
                        coef[3] <= i_cfg_wdata[31:0];
                    end
                    CFG_C45: begin
                        coef[4] <= i_cfg_wdata[63:32];
                        coef[5] <= i_cfg_wdata[31:0];
                    end
                    CFG_C67: begin
                        coef[6] <= i_cfg_wdata[63:32];
                        coef[7] <= i_cfg_wdata[31:0];
                    end
                    CFG_C8: coef[8] <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_points.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (i_zero_denominator) o_zden_seen <= o_zden_seen + 1;
                    if (i_overflow) o_ovf_seen <= o_ovf_seen + 1;
                    if (want.px !== i_out_x) begin
                        $error("out_x expected %h got %h", want.px, i_out_x);
                        mismatch = 1'b1;
                    end
                    if (want.py !== i_out_y) begin
                        $error("out_y expected %h got %h", want.py, i_out_y);
                        mismatch = 1'b1;
                    end
                    if (want.zden !== i_zero_denominator) begin
                        $error("zero_denominator expected %b got %b", want.zden,
                               i_zero_denominator);
                        mismatch = 1'b1;
                    end
                    if (want.ovf !== i_overflow) begin
                        $error("overflow expected %b got %b", want.ovf, i_overflow);
                        mismatch = 1'b1;
                    end
                    if (mismatch) o_fail_count <= o_fail_count + 1;
                end
            end
            if (i_valid && !i_in_stall)
                expected_points.push_back(map_point(i_x, i_y));
        end
    end

endmodule

/* verif/perspective_point_transform_tb.sv */
// ---------------------------------------------------------------------------
// perspective_point_transform_tb
// drives points through several coefficient sets in both modes with random
// gaps and output stalls; the checker predicts and compares every result
// ---------------------------------------------------------------------------
module perspective_point_transform_tb;
    import ppt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 2000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = CFG_MODE;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_x = '0;
    logic signed [COORD_W-1:0] i_y = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [OUT_W-1:0]   o_out_x, o_out_y;
    logic                      o_zero_denominator, o_overflow;

    int fail_count, pending, results_seen, zden_seen, ovf_seen;
    int idle_cycles;
    int out_wait;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    perspective_point_transform DUT (.*);

    perspective_point_transform_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_valid, .i_in_stall(o_stall), .i_x, .i_y,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_x(o_out_x),
        .i_out_y(o_out_y), .i_zero_denominator(o_zero_denominator),
        .i_overflow(o_overflow),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_zden_seen(zden_seen), .o_ovf_seen(ovf_seen)
    );

    // receiver: draws a random stall, possibly none, before each word it takes
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            out_wait <= 0;
        end else if (i_stall) begin
            if (out_wait <= 1) i_stall <= 1'b0;
            out_wait <= out_wait - 1;
        end else if (o_valid) begin
            w = $urandom_range(0, 4);
            out_wait <= w;
            i_stall  <= (w != 0);
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d words pending", pending);
            $display("[perspective_point_transform] ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_x <= x;
        i_y <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord(input int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'd32;
            2: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 2047)) - 16'd1024;
        endcase
    endfunction

    function automatic logic [31:0] rand_coef(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
            2: return 32'($urandom_range(0, 64)) - 32'd32;
            default: return 32'h0;
        endcase
    endfunction

    logic [15:0] dir_x [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
                               16'h8000, 16'h0001, 16'hFFFF, 16'h1234};
    logic [15:0] dir_y [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000,
                               16'h7FFF, 16'hFFFF, 16'h0001, 16'hEDCB};

    initial begin
        int kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity at reset, extremes of the coordinates
        for (int i = 0; i < 8; i++) send_point(dir_x[i], dir_y[i], 1'b0);
        end_burst();
        drain_pipe();

        // extreme coefficients in affine mode: saturation both ways
        cfg_write(CFG_C01, 64'h7FFF_FFFF_8000_0000);
        cfg_write(CFG_C23, 64'h7FFF_FFFF_7FFF_FFFF);
        cfg_write(CFG_C45, 64'h8000_0000_8000_0000);
        for (int i = 0; i < 8; i++) send_point(dir_x[i], dir_y[i], 1'b1);
        end_burst();
        drain_pipe();

        // perspective with zero denominator at the origin and on a line
        cfg_write(CFG_MODE, {63'b0, MODE_PERSPECTIVE});
        cfg_write(CFG_C01, 64'h0001_0000_0000_0000);
        cfg_write(CFG_C23, 64'hFFFF_0000_0000_0000);
        cfg_write(CFG_C45, 64'h0001_0000_0000_0000);
        cfg_write(CFG_C67, 64'h0001_0000_FFFF_0000);
        cfg_write(CFG_C8, 64'h0);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'hFFF0, 16'hFFF0, 1'b0);
        send_point(16'd3, 16'd1, 1'b0);
        send_point(16'd1, 16'd3, 1'b0);
        send_point(16'h7FFF, 16'h8000, 1'b0);
        end_burst();
        drain_pipe();
        cfg_write(CFG_C8, 64'h0000_0000_8000_0000);
        cfg_write(CFG_C67, 64'h0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h0001, 1'b0);
        end_burst();
        drain_pipe();

        // random phases, each with its own coefficient set
        for (int ph = 0; ph < 19; ph++) begin
            kind = $urandom_range(0, 3);
            cfg_write(CFG_MODE, {63'b0, 1'($urandom)});
            cfg_write(CFG_C01, {rand_coef(kind), rand_coef($urandom_range(0, 3))});
            cfg_write(CFG_C23, {rand_coef(kind), rand_coef($urandom_range(0, 3))});
            cfg_write(CFG_C45, {rand_coef($urandom_range(0, 3)), rand_coef(kind)});
            cfg_write(CFG_C67, {rand_coef($urandom_range(1, 3)),
                                rand_coef($urandom_range(1, 3))});
            cfg_write(CFG_C8, {32'b0, rand_coef($urandom_range(0, 3))});
            for (int i = 0; i < 50; i++) begin
                send_point(rand_coord($urandom_range(0, 3)),
                           rand_coord($urandom_range(0, 3)), (ph % 4) != 1);
                // hold off until the pipe is empty once mid phase
                if (ph == 3 && i == 25) begin
                    i_valid <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
            end
            end_burst();
            drain_pipe();
        end

        $display("covered %0d results over affine and perspective sets, %0d zero",
                 results_seen, zden_seen);
        $display("denominators and %0d saturated words", ovf_seen);
        if (fail_count == 0)
            $display("[perspective_point_transform] OK");
        else
            $display("[perspective_point_transform] ERROR");
        $finish;
    end

endmodule

/* perspective_point_transform.f */
+incdir+src
src/ppt_pkg.sv
src/perspective_point_transform.sv
verif/perspective_point_transform_checker.sv
verif/perspective_point_transform_tb.sv
